### src/pid_pkg.sv
// shared types and constants for the periodic image distance search
`default_nettype none
package pid_pkg;

    localparam int POS_W   = 21;
    localparam int LEN_W   = 16;
    localparam int COORD_W = 19;
    localparam int NUM_W   = 22;
    localparam int SQ_W    = 32;
    localparam int ROOT_W  = 16;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 2;

    localparam logic [CNT_W-1:0] MAX_IMAGES = 6'd63;

    localparam logic [IDX_W-1:0] REG_LATTICE_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_LATTICE_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_LATTICE_C = 2'd2;

    localparam logic [LEN_W-1:0] LATTICE_RESET = 16'd2560;

    typedef logic signed [COORD_W-1:0] coord_t;

    // remainder unit request and response
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [LEN_W-1:0]        den;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] rem;
    } rem_rsp_t;

    // square root unit request and response
    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage
`default_nettype wire

### src/pid_rem.sv
// bit-serial floor remainder of a signed value by an unsigned length
`default_nettype none
module pid_rem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pid_pkg::rem_req_t req,
    output pid_pkg::rem_rsp_t      rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [4:0]                  cnt_reg;
    logic [pid_pkg::NUM_W-1:0]   mag_reg;
    logic [pid_pkg::LEN_W-1:0]   r_reg;
    logic [pid_pkg::LEN_W-1:0]   den_reg;
    logic                        neg_reg;
    logic [pid_pkg::LEN_W:0]     trial;
    logic [pid_pkg::LEN_W-1:0]   r_next;

    assign trial  = {r_reg, mag_reg[pid_pkg::NUM_W-1]};
    assign r_next = (trial >= {1'b0, den_reg}) ? pid_pkg::LEN_W'(trial - {1'b0, den_reg})
                                               : trial[pid_pkg::LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(pid_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mag_reg <= req.num[pid_pkg::NUM_W-1] ? pid_pkg::NUM_W'(-req.num)
                                                 : pid_pkg::NUM_W'(req.num);
            neg_reg <= req.num[pid_pkg::NUM_W-1];
            den_reg <= req.den;
            r_reg   <= '0;
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            mag_reg <= {mag_reg[pid_pkg::NUM_W-2:0], 1'b0};
        end
    end

    // negative numerator folds back into [0, len)
    assign rsp.done = done_reg;
    assign rsp.rem  = (neg_reg && r_reg != '0) ? den_reg - r_reg : r_reg;

endmodule
`default_nettype wire

### src/pid_isqrt.sv
// digit-by-digit floored integer square root, one result bit per cycle
`default_nettype none
module pid_isqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pid_pkg::sqrt_req_t req,
    output pid_pkg::sqrt_rsp_t      rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [3:0]                   cnt_reg;
    logic [pid_pkg::SQ_W-1:0]     v_reg;
    logic [pid_pkg::ROOT_W:0]     rem_reg;
    logic [pid_pkg::ROOT_W-1:0]   root_reg;
    logic [pid_pkg::ROOT_W+2:0]   acc;
    logic [pid_pkg::ROOT_W+2:0]   trial;

    assign acc   = {rem_reg, v_reg[pid_pkg::SQ_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(pid_pkg::ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            v_reg    <= req.value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[pid_pkg::SQ_W-3:0], 2'b00};
            if (acc >= trial)
            begin
                rem_reg  <= (pid_pkg::ROOT_W+1)'(acc - trial);
                root_reg <= {root_reg[pid_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= acc[pid_pkg::ROOT_W:0];
                root_reg <= {root_reg[pid_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule
`default_nettype wire

### src/periodic_image_distances_unit.sv
// top level: sequencer walking periodic image shifts with shared remainder, sqrt and square units
//
//   channel  | handshake          | carries
//   ---------+--------------------+------------------------------------------------
//   input    | in_valid/in_ready  | two positions, cutoff_len, max_count
//   output   | out_valid/out_ready| image offsets and distance, then a status item
//   config   | cfg_write          | lattice_a/b/c by cfg_index, cfg_data
//
// setup takes 13 remainder passes.
// each a shift with room left costs a sqrt plus two remainder passes, each visited c shift
// a square and a compare, each emitted image a sqrt; total grows with the shift grid.
// in_ready is high only between queries; one query runs until its status item is taken.
// a stalled output holds the walk; reset returns the lattice lengths to 2560.
`default_nettype none
module periodic_image_distances_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [pid_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [pid_pkg::LEN_W-1:0]          cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [pid_pkg::POS_W-1:0]   first_a,
    input  wire logic signed [pid_pkg::POS_W-1:0]   first_b,
    input  wire logic signed [pid_pkg::POS_W-1:0]   first_c,
    input  wire logic signed [pid_pkg::POS_W-1:0]   second_a,
    input  wire logic signed [pid_pkg::POS_W-1:0]   second_b,
    input  wire logic signed [pid_pkg::POS_W-1:0]   second_c,
    input  wire logic [pid_pkg::LEN_W-1:0]          cutoff_len,
    input  wire logic [pid_pkg::CNT_W-1:0]          max_count,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    is_image,
    output logic signed [pid_pkg::COORD_W-1:0]      offset_a,
    output logic signed [pid_pkg::COORD_W-1:0]      offset_b,
    output logic signed [pid_pkg::COORD_W-1:0]      offset_c,
    output logic [pid_pkg::ROOT_W-1:0]              distance,
    output logic                                    limit_hit,
    output logic                                    last
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_REM_GO  = 5'd1;
    localparam logic [4:0] S_REM_WT  = 5'd2;
    localparam logic [4:0] S_CHK     = 5'd3;
    localparam logic [4:0] S_MSQ1    = 5'd4;
    localparam logic [4:0] S_MSQ2    = 5'd5;
    localparam logic [4:0] S_A       = 5'd6;
    localparam logic [4:0] S_A2      = 5'd7;
    localparam logic [4:0] S_AS      = 5'd8;
    localparam logic [4:0] S_BL      = 5'd9;
    localparam logic [4:0] S_BLW     = 5'd10;
    localparam logic [4:0] S_BH      = 5'd11;
    localparam logic [4:0] S_BHW     = 5'd12;
    localparam logic [4:0] S_B       = 5'd13;
    localparam logic [4:0] S_B2      = 5'd14;
    localparam logic [4:0] S_C       = 5'd15;
    localparam logic [4:0] S_C2      = 5'd16;
    localparam logic [4:0] S_CS      = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;
    localparam logic [4:0] S_SOUT    = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic [pid_pkg::LEN_W-1:0]           lat_reg [3];
    logic [pid_pkg::LEN_W-1:0]           len [3];

    logic signed [pid_pkg::POS_W-1:0]    pos_f_reg [3];
    logic signed [pid_pkg::POS_W-1:0]    pos_s_reg [3];
    logic [pid_pkg::LEN_W-1:0]           cut_reg;
    logic [pid_pkg::CNT_W-1:0]           lim_reg;
    logic [pid_pkg::CNT_W-1:0]           cnt_reg;

    logic [1:0]                          ax_reg;
    logic [1:0]                          j_reg;
    logic [1:0]                          ax_idx;
    logic [pid_pkg::LEN_W-1:0]           tmp_reg;
    logic signed [pid_pkg::LEN_W:0]      d_reg [3];
    pid_pkg::coord_t                     rlo_reg [3];
    pid_pkg::coord_t                     rhi_reg [3];
    logic [pid_pkg::LEN_W-1:0]           rem0_reg;

    logic [pid_pkg::SQ_W-1:0]            cutsq_reg;
    logic [pid_pkg::SQ_W-1:0]            msq_reg;
    logic [pid_pkg::SQ_W-1:0]            asq_reg;
    logic [pid_pkg::SQ_W:0]              absq_reg;
    logic [pid_pkg::SQ_W-1:0]            prod_reg;
    logic [pid_pkg::ROOT_W-1:0]          s_reg;

    pid_pkg::coord_t                     ra_reg;
    pid_pkg::coord_t                     rb_reg;
    pid_pkg::coord_t                     rc_reg;
    pid_pkg::coord_t                     bhi_reg;

    logic                                out_img_reg;
    pid_pkg::coord_t                     out_a_reg;
    pid_pkg::coord_t                     out_b_reg;
    pid_pkg::coord_t                     out_c_reg;
    logic [pid_pkg::ROOT_W-1:0]          out_dist_reg;
    logic                                out_hit_reg;

    pid_pkg::coord_t                     mul_op;
    logic signed [2*pid_pkg::COORD_W-1:0] prod_full;
    pid_pkg::rem_req_t                   rem_req;
    pid_pkg::rem_rsp_t                   rem_rsp;
    pid_pkg::sqrt_req_t                  sqrt_req;
    pid_pkg::sqrt_rsp_t                  sqrt_rsp;

    pid_pkg::coord_t                     cut_c;
    pid_pkg::coord_t                     d_c;
    pid_pkg::coord_t                     d2_c;
    pid_pkg::coord_t                     d1_c;
    pid_pkg::coord_t                     s_c;
    pid_pkg::coord_t                     rem_c;
    pid_pkg::coord_t                     rem_sum;
    pid_pkg::coord_t                     cand1;
    pid_pkg::coord_t                     cand2;
    pid_pkg::coord_t                     cl1;
    pid_pkg::coord_t                     cl2;
    pid_pkg::coord_t                     blo_c;
    pid_pkg::coord_t                     bhi_c;
    logic signed [pid_pkg::SQ_W+2:0]     room;
    logic [pid_pkg::SQ_W+1:0]            tsum;
    logic                                load_img;
    logic                                load_stat;
    logic                                stat_hit;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_len
            assign len[g] = (lat_reg[g] == '0) ? pid_pkg::LEN_W'(1) : lat_reg[g];
        end
    endgenerate

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg[0] <= pid_pkg::LATTICE_RESET;
            lat_reg[1] <= pid_pkg::LATTICE_RESET;
            lat_reg[2] <= pid_pkg::LATTICE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pid_pkg::REG_LATTICE_A: lat_reg[0] <= cfg_data;
                pid_pkg::REG_LATTICE_B: lat_reg[1] <= cfg_data;
                pid_pkg::REG_LATTICE_C: lat_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ax_idx  = (ax_reg == 2'd3) ? 2'd2 : ax_reg;
    assign cut_c   = pid_pkg::coord_t'({3'b000, cut_reg});
    assign d_c     = pid_pkg::coord_t'(d_reg[ax_idx]);
    assign d1_c    = pid_pkg::coord_t'(d_reg[1]);
    assign d2_c    = pid_pkg::coord_t'(d_reg[2]);
    assign s_c     = pid_pkg::coord_t'({3'b000, s_reg});
    assign rem_c   = pid_pkg::coord_t'({3'b000, rem_rsp.rem});

    // nearest c offsets on either side of zero, clamped into the c range
    assign cand1 = -pid_pkg::coord_t'({3'b000, rem0_reg});
    assign cand2 = pid_pkg::coord_t'({3'b000, len[2]}) - pid_pkg::coord_t'({3'b000, rem0_reg});
    assign cl1   = (cand1 < rlo_reg[2]) ? rlo_reg[2] : ((cand1 > rhi_reg[2]) ? rhi_reg[2] : cand1);
    assign cl2   = (cand2 < rlo_reg[2]) ? rlo_reg[2] : ((cand2 > rhi_reg[2]) ? rhi_reg[2] : cand2);

    assign blo_c = ((rem_c - s_c) < rlo_reg[1]) ? rlo_reg[1] : (rem_c - s_c);
    assign bhi_c = ((s_c - rem_c) > rhi_reg[1]) ? rhi_reg[1] : (s_c - rem_c);

    assign room = $signed({3'b000, cutsq_reg}) - $signed({3'b000, prod_reg})
                - $signed({3'b000, msq_reg});
    assign tsum = {1'b0, absq_reg} + {2'b00, prod_reg};

    // shared squaring multiplier, registered
    assign prod_full = mul_op * mul_op;
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[pid_pkg::SQ_W-1:0];
    end

    always_comb
    begin
        mul_op = cut_c;
        case (state_reg)
            S_CHK:  mul_op = cl1;
            S_MSQ1: mul_op = cl2;
            S_A:    mul_op = ra_reg;
            S_B:    mul_op = rb_reg;
            S_C:    mul_op = rc_reg;
            default: mul_op = cut_c;
        endcase
    end

    // remainder requests
    always_comb
    begin
        rem_req.start = 1'b0;
        rem_req.den   = len[ax_idx];
        rem_sum       = '0;
        rem_req.num   = '0;
        case (state_reg)
            S_REM_GO:
            begin
                rem_req.start = 1'b1;
                if (ax_reg == 2'd3)
                begin
                    rem_sum     = -d2_c;
                    rem_req.num = pid_pkg::NUM_W'(rem_sum);
                end
                else
                begin
                    case (j_reg)
                        2'd0: rem_req.num = pid_pkg::NUM_W'(pos_s_reg[ax_idx]);
                        2'd1: rem_req.num = pid_pkg::NUM_W'(pos_f_reg[ax_idx]);
                        2'd2:
                        begin
                            rem_sum     = cut_c + d_c;
                            rem_req.num = pid_pkg::NUM_W'(rem_sum);
                        end
                        default:
                        begin
                            rem_sum     = cut_c - d_c;
                            rem_req.num = pid_pkg::NUM_W'(rem_sum);
                        end
                    endcase
                end
            end
            S_BL:
            begin
                rem_req.start = 1'b1;
                rem_req.den   = len[1];
                rem_sum       = s_c + d1_c;
                rem_req.num   = pid_pkg::NUM_W'(rem_sum);
            end
            S_BH:
            begin
                rem_req.start = 1'b1;
                rem_req.den   = len[1];
                rem_sum       = s_c - d1_c;
                rem_req.num   = pid_pkg::NUM_W'(rem_sum);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        sqrt_req.start = 1'b0;
        sqrt_req.value = '0;
        if (state_reg == S_A2 && room > 0)
        begin
            sqrt_req.start = 1'b1;
            sqrt_req.value = pid_pkg::SQ_W'(room - 1);
        end
        else if (state_reg == S_C2 && tsum < {2'b00, cutsq_reg})
        begin
            sqrt_req.start = 1'b1;
            sqrt_req.value = tsum[pid_pkg::SQ_W-1:0];
        end
    end

    pid_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    pid_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        load_img   = 1'b0;
        load_stat  = 1'b0;
        stat_hit   = 1'b0;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_REM_GO;
            S_REM_GO: state_next = S_REM_WT;
            S_REM_WT:
            begin
                if (rem_rsp.done)
                    state_next = (ax_reg == 2'd3) ? S_CHK : S_REM_GO;
            end
            S_CHK:
            begin
                if (rlo_reg[2] > rhi_reg[2])
                begin
                    load_stat  = 1'b1;
                    state_next = S_SOUT;
                end
                else
                    state_next = S_MSQ1;
            end
            S_MSQ1:   state_next = S_MSQ2;
            S_MSQ2:   state_next = S_A;
            S_A:
            begin
                if (ra_reg > rhi_reg[0])
                begin
                    load_stat  = 1'b1;
                    state_next = S_SOUT;
                end
                else
                    state_next = S_A2;
            end
            S_A2:     state_next = (room > 0) ? S_AS : S_A;
            S_AS:     if (sqrt_rsp.done) state_next = S_BL;
            S_BL:     state_next = S_BLW;
            S_BLW:    if (rem_rsp.done) state_next = S_BH;
            S_BH:     state_next = S_BHW;
            S_BHW:    if (rem_rsp.done) state_next = S_B;
            S_B:      state_next = (rb_reg > bhi_reg) ? S_A : S_B2;
            S_B2:     state_next = S_C;
            S_C:      state_next = (rc_reg > rhi_reg[2]) ? S_B : S_C2;
            S_C2:     state_next = (tsum < {2'b00, cutsq_reg}) ? S_CS : S_C;
            S_CS:
            begin
                if (sqrt_rsp.done)
                begin
                    load_img   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (cnt_reg == lim_reg)
                    begin
                        load_stat  = 1'b1;
                        stat_hit   = 1'b1;
                        state_next = S_SOUT;
                    end
                    else
                        state_next = S_C;
                end
            end
            S_SOUT:   if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_valid)
            begin
                ax_reg  <= '0;
                j_reg   <= '0;
                cnt_reg <= '0;
            end
            else if (state_reg == S_REM_WT && rem_rsp.done && ax_reg != 2'd3)
            begin
                j_reg <= j_reg + 2'd1;
                if (j_reg == 2'd3)
                    ax_reg <= ax_reg + 2'd1;
            end
            if (load_img)
                cnt_reg <= cnt_reg + pid_pkg::CNT_W'(1);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            pos_f_reg[0] <= first_a;
            pos_f_reg[1] <= first_b;
            pos_f_reg[2] <= first_c;
            pos_s_reg[0] <= second_a;
            pos_s_reg[1] <= second_b;
            pos_s_reg[2] <= second_c;
            cut_reg      <= cutoff_len;
            lim_reg      <= (max_count == '0) ? pid_pkg::CNT_W'(1)
                          : ((max_count > pid_pkg::MAX_IMAGES) ? pid_pkg::MAX_IMAGES : max_count);
        end

        if (state_reg == S_REM_WT && rem_rsp.done)
        begin
            if (ax_reg == 2'd3)
                rem0_reg <= rem_rsp.rem;
            else
            begin
                case (j_reg)
                    2'd0: tmp_reg <= rem_rsp.rem;
                    2'd1: d_reg[ax_idx] <= $signed({1'b0, tmp_reg}) - $signed({1'b0, rem_rsp.rem});
                    2'd2: rlo_reg[ax_idx] <= rem_c - cut_c;
                    default: rhi_reg[ax_idx] <= cut_c - rem_c;
                endcase
            end
        end

        case (state_reg)
            S_CHK:  cutsq_reg <= prod_reg;
            S_MSQ1: msq_reg <= prod_reg;
            S_MSQ2:
            begin
                if (prod_reg < msq_reg)
                    msq_reg <= prod_reg;
                ra_reg <= rlo_reg[0];
            end
            S_A2:
            begin
                asq_reg <= prod_reg;
                if (!(room > 0))
                    ra_reg <= ra_reg + pid_pkg::coord_t'({3'b000, len[0]});
            end
            S_AS:   if (sqrt_rsp.done) s_reg <= sqrt_rsp.root;
            S_BLW:  if (rem_rsp.done) rb_reg <= blo_c;
            S_BHW:  if (rem_rsp.done) bhi_reg <= bhi_c;
            S_B:
            begin
                if (rb_reg > bhi_reg)
                    ra_reg <= ra_reg + pid_pkg::coord_t'({3'b000, len[0]});
            end
            S_B2:
            begin
                absq_reg <= {1'b0, asq_reg} + {1'b0, prod_reg};
                rc_reg   <= rlo_reg[2];
            end
            S_C:
            begin
                if (rc_reg > rhi_reg[2])
                    rb_reg <= rb_reg + pid_pkg::coord_t'({3'b000, len[1]});
            end
            S_C2:
            begin
                if (!(tsum < {2'b00, cutsq_reg}))
                    rc_reg <= rc_reg + pid_pkg::coord_t'({3'b000, len[2]});
            end
            S_OUT:
            begin
                if (out_ready && cnt_reg != lim_reg)
                    rc_reg <= rc_reg + pid_pkg::coord_t'({3'b000, len[2]});
            end
            default: ;
        endcase

        if (load_img)
        begin
            out_img_reg  <= 1'b1;
            out_a_reg    <= ra_reg;
            out_b_reg    <= rb_reg;
            out_c_reg    <= rc_reg;
            out_dist_reg <= sqrt_rsp.root;
            out_hit_reg  <= 1'b0;
        end
        else if (load_stat)
        begin
            out_img_reg  <= 1'b0;
            out_a_reg    <= '0;
            out_b_reg    <= '0;
            out_c_reg    <= '0;
            out_dist_reg <= '0;
            out_hit_reg  <= stat_hit;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT) || (state_reg == S_SOUT);
    assign is_image  = out_img_reg;
    assign offset_a  = out_a_reg;
    assign offset_b  = out_b_reg;
    assign offset_c  = out_c_reg;
    assign distance  = out_dist_reg;
    assign limit_hit = out_hit_reg;
    assign last      = !out_img_reg;

endmodule
`default_nettype wire

### src/pid_checker.sv
// port-level checks for the periodic image distance unit, bound to the top level
`default_nettype none
module pid_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic is_image,
    input wire logic limit_hit,
    input wire logic last
);

    // one query at a time: never ready while a result is on offer
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output valid");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_image) |-> last)
        else $error("status transaction without last");

    a_image_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_image) |-> (!last && !limit_hit))
        else $error("image transaction carries status flags");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && !out_valid))
        else $error("unit not busy after input transaction");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("unit not ready after final transaction");

endmodule

bind periodic_image_distances_unit pid_checker u_pid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_image  (is_image),
    .limit_hit (limit_hit),
    .last      (last)
);
`default_nettype wire

### test/image_search_checker.sv
// checker: predicts periodic image results from accepted queries and compares the output channel
`default_nettype none
module image_search_checker
    import pid_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [IDX_W-1:0]          cfg_index,
    input  wire logic [LEN_W-1:0]          cfg_data,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire logic signed [POS_W-1:0]   first_a,
    input  wire logic signed [POS_W-1:0]   first_b,
    input  wire logic signed [POS_W-1:0]   first_c,
    input  wire logic signed [POS_W-1:0]   second_a,
    input  wire logic signed [POS_W-1:0]   second_b,
    input  wire logic signed [POS_W-1:0]   second_c,
    input  wire logic [LEN_W-1:0]          cutoff_len,
    input  wire logic [CNT_W-1:0]          max_count,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic                      is_image,
    input  wire logic signed [COORD_W-1:0] offset_a,
    input  wire logic signed [COORD_W-1:0] offset_b,
    input  wire logic signed [COORD_W-1:0] offset_c,
    input  wire logic [ROOT_W-1:0]         distance,
    input  wire logic                      limit_hit,
    input  wire logic                      last,
    output int                             mismatches,
    output int                             pending,
    output int                             images_seen,
    output int                             queries_done,
    output int                             limits_seen
);

    typedef struct packed {
        logic               is_image;
        logic [COORD_W-1:0] off_a;
        logic [COORD_W-1:0] off_b;
        logic [COORD_W-1:0] off_c;
        logic [ROOT_W-1:0]  root_val;
        logic               hit;
        logic               last;
    } image_result_t;

    image_result_t expected_results[$];
    logic [LEN_W-1:0] cell_len[3];

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint wrap_coord(longint x, longint len);
        longint r;
        r = x % len;
        if (r < 0)
            r = r + len;
        return r;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic void push_result(logic img, longint ra, longint rb, longint rc,
                                        longint root_in, logic hit, logic lst);
        image_result_t r;
        r.is_image = img;
        r.off_a = ra[COORD_W-1:0];
        r.off_b = rb[COORD_W-1:0];
        r.off_c = rc[COORD_W-1:0];
        r.root_val = root_in[ROOT_W-1:0];
        r.hit = hit;
        r.last = lst;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // walks image shifts a, b, c in order and queues each qualifying image up to the limit, plus status
    function automatic void predict_images(longint p1[3], longint p2[3], longint cut,
                                           int cnt);
        longint len[3], d[3], lo[3], hi[3];
        longint cut_sq, c0, m_sq, cc, rz, a, b, c, ra, a_sq, room, s, blo, bhi;
        longint rb, ab_sq, rc, t;
        int n, limit;
        bit hit;
        n = 0;
        hit = 0;
        cut_sq = cut * cut;
        limit = (cnt == 0) ? 1 : cnt;
        if (limit > int'(MAX_IMAGES))
            limit = int'(MAX_IMAGES);
        for (int i = 0; i < 3; i++)
        begin
            len[i] = (cell_len[i] == 0) ? 1 : longint'(cell_len[i]);
            d[i] = wrap_coord(p2[i], len[i]) - wrap_coord(p1[i], len[i]);
            lo[i] = -floor_quot(cut + d[i], len[i]);
            hi[i] = floor_quot(cut - d[i], len[i]);
        end
        if (lo[2] <= hi[2])
        begin
            c0 = floor_quot(-d[2], len[2]);
            m_sq = -1;
            for (longint k = c0; k <= c0 + 1; k++)
            begin
                cc = (k < lo[2]) ? lo[2] : ((k > hi[2]) ? hi[2] : k);
                rz = cc * len[2] + d[2];
                if (m_sq < 0 || rz * rz < m_sq)
                    m_sq = rz * rz;
            end
            for (a = lo[0]; a <= hi[0] && !hit; a++)
            begin
                ra = a * len[0] + d[0];
                a_sq = ra * ra;
                room = cut_sq - a_sq - m_sq;
                if (room > 0)
                begin
                    s = root_floor(longint'(room - 1));
                    blo = -floor_quot(s + d[1], len[1]);
                    bhi = floor_quot(s - d[1], len[1]);
                    if (blo < lo[1])
                        blo = lo[1];
                    if (bhi > hi[1])
                        bhi = hi[1];
                    for (b = blo; b <= bhi && !hit; b++)
                    begin
                        rb = b * len[1] + d[1];
                        ab_sq = a_sq + rb * rb;
                        for (c = lo[2]; c <= hi[2] && !hit; c++)
                        begin
                            rc = c * len[2] + d[2];
                            t = ab_sq + rc * rc;
                            if (t < cut_sq)
                            begin
                                push_result(1'b1, ra, rb, rc, root_floor(t), 1'b0, 1'b0);
                                n++;
                                if (n >= limit)
                                    hit = 1;
                            end
                        end
                    end
                end
            end
        end
        push_result(1'b0, 0, 0, 0, 0, hit, 1'b1);
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint p1[3], p2[3];
        image_result_t got, want;
        if (!rst_n)
        begin
            cell_len[0] <= LATTICE_RESET;
            cell_len[1] <= LATTICE_RESET;
            cell_len[2] <= LATTICE_RESET;
            expected_results.delete();
            mismatches = 0;
            images_seen = 0;
            queries_done = 0;
            limits_seen = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LATTICE_A: cell_len[0] <= cfg_data;
                    REG_LATTICE_B: cell_len[1] <= cfg_data;
                    REG_LATTICE_C: cell_len[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                p1[0] = first_a;
                p1[1] = first_b;
                p1[2] = first_c;
                p2[0] = second_a;
                p2[1] = second_b;
                p2[2] = second_c;
                predict_images(p1, p2, longint'(cutoff_len), int'(max_count));
            end
            if (out_valid && out_ready)
            begin
                got = {is_image, offset_a, offset_b, offset_c, distance, limit_hit, last};
                if (is_image)
                    images_seen++;
                else
                    queries_done++;
                if (!is_image && limit_hit)
                    limits_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: img %b/%b a %0d/%0d b %0d/%0d c %0d/%0d",
                                      " dist %0d/%0d hit %b/%b last %b/%b (expected/actual)"},
                                     want.is_image, got.is_image,
                                     $signed(want.off_a), $signed(got.off_a),
                                     $signed(want.off_b), $signed(got.off_b),
                                     $signed(want.off_c), $signed(got.off_c),
                                     want.root_val, got.root_val, want.hit, got.hit,
                                     want.last, got.last);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

### test/periodic_image_distances_unit_test.sv
// testbench top: query stimulus, lattice settings, output stalls and verdict
`default_nettype none
module periodic_image_distances_unit_test;
    import pid_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0] cfg_data;
    logic in_valid, in_ready;
    logic signed [POS_W-1:0] first_a, first_b, first_c, second_a, second_b, second_c;
    logic [LEN_W-1:0] cutoff_len;
    logic [CNT_W-1:0] max_count;
    logic out_valid, out_ready;
    logic is_image, limit_hit, last;
    logic signed [COORD_W-1:0] offset_a, offset_b, offset_c;
    logic [ROOT_W-1:0] distance;
    int mismatches, pending, images_seen, queries_done, limits_seen;
    bit no_idle;
    int idle_cycles = 0;

    periodic_image_distances_unit DUT (.*);

    image_search_checker checker_inst (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall before each transaction
    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    task automatic send_query(logic signed [POS_W-1:0] fa, logic signed [POS_W-1:0] fb,
                              logic signed [POS_W-1:0] fc, logic signed [POS_W-1:0] sa,
                              logic signed [POS_W-1:0] sb, logic signed [POS_W-1:0] sc,
                              logic [LEN_W-1:0] cut, logic [CNT_W-1:0] cnt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        first_a <= fa;
        first_b <= fb;
        first_c <= fc;
        second_a <= sa;
        second_b <= sb;
        second_c <= sc;
        cutoff_len <= cut;
        max_count <= cnt;
        in_valid <= 1;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] any_pos();
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    task automatic random_query(int max_cut);
        logic signed [POS_W-1:0] fa, fb, fc;
        logic [LEN_W-1:0] cut;
        fa = any_pos();
        fb = any_pos();
        fc = any_pos();
        cut = ($urandom_range(0, 11) == 0) ? '0 : LEN_W'($urandom_range(1, max_cut));
        if ($urandom_range(0, 7) == 0)
            send_query(fa, fb, fc, fa, fb, fc, cut, CNT_W'($urandom_range(0, 63)));
        else
            send_query(fa, fb, fc, any_pos(), any_pos(), any_pos(), cut,
                       CNT_W'($urandom_range(0, 63)));
    endtask

    // sender holds off until the block has drained, then lattice lengths may change
    task automatic drain();
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_lattice(logic [LEN_W-1:0] la, logic [LEN_W-1:0] lb,
                               logic [LEN_W-1:0] lc);
        cfg_write <= 1;
        cfg_index <= REG_LATTICE_A;
        cfg_data <= la;
        @(negedge clk);
        cfg_index <= REG_LATTICE_B;
        cfg_data <= lb;
        @(negedge clk);
        cfg_index <= REG_LATTICE_C;
        cfg_data <= lc;
        @(negedge clk);
        cfg_write <= 0;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_write = 0;
        cfg_index = REG_LATTICE_A;
        cfg_data = 0;
        in_valid = 0;
        first_a = 0;
        first_b = 0;
        first_c = 0;
        second_a = 0;
        second_b = 0;
        second_c = 0;
        cutoff_len = 0;
        max_count = 0;
        no_idle = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed queries on the reset lattice
        send_query(0, 0, 0, 0, 0, 0, 0, 5);                     // zero cutoff
        send_query(0, 0, 0, 0, 0, 0, 1, 1);                     // limit met on sole image
        send_query(0, 0, 0, 0, 0, 0, 1, 2);
        send_query(100, 200, 300, 100, 200, 300, 2560, 0);      // zero limit
        send_query(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575, 3000, 63);
        send_query(1048575, -1048576, 1048575, -1048576, 1048575, -1048576, 6000, 63);
        send_query(0, 0, 0, 1280, 1280, 1280, 2300, 63);
        send_query(5, -7, 9, 2555, 2559, 1, 65535, 63);          // widest cutoff
        send_query(-1, -1, -1, 0, 0, 0, 10, 63);
        send_query(123, 456, 789, 2000, 100, 2400, 12800, 10);
        no_idle = 1;
        send_query(0, 0, 0, 0, 0, 0, 2560, 63);
        send_query(-2560, 2560, 5120, 0, 0, 0, 2561, 63);
        no_idle = 0;
        repeat (8) random_query(12800);
        drain();

        set_lattice(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (28) random_query(65535);
        drain();

        // zero length is taken as one
        set_lattice(1, 0, 3);
        no_idle = 1;
        repeat (10) random_query(5);
        no_idle = 0;
        repeat (14) random_query(5);
        drain();

        set_lattice(LEN_W'($urandom_range(64, 4000)), LEN_W'($urandom_range(64, 4000)),
                    LEN_W'($urandom_range(64, 4000)));
        repeat (28) random_query(300);
        drain();

        set_lattice(300, 2560, 65535);
        repeat (28) random_query(1500);
        drain();

        repeat (50) @(negedge clk);
        $display("ran %0d queries over five lattice settings: %0d images, %0d limit stops",
                 queries_done, images_seen, limits_seen);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
src/pid_pkg.sv
src/pid_rem.sv
src/pid_isqrt.sv
src/periodic_image_distances_unit.sv
src/pid_checker.sv
test/image_search_checker.sv
test/periodic_image_distances_unit_test.sv
